[hdl/front_to_back_alpha_compositor_defines.svh]
// Assertion macros used by the compositor back end.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef FRONT_TO_BACK_ALPHA_COMPOSITOR_DEFINES_SVH
`define FRONT_TO_BACK_ALPHA_COMPOSITOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTBAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTBAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ftbac_pkg.sv]
// Shared types, constants and helper functions of the alpha compositor.
// No dependencies; the compositor modules and the testbench import this package.
package ftbac_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int VAL_W = FRACTION_BITS + 1;
  localparam logic [VAL_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  localparam int SPP_W = 13;
  localparam int PIF_W = 21;
  localparam int SC_W = 12;
  localparam int PC_W = 20;
  localparam logic [SPP_W-1:0] MAX_SPP = 13'd4096;
  localparam logic [PIF_W-1:0] MAX_PIF = 21'd1048576;
  localparam logic [SPP_W-1:0] SPP_RESET = 13'd64;
  localparam logic [PIF_W-1:0] PIF_RESET = 21'd65536;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 21;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_PIXEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_IN_FRAME = 2'd1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [VAL_W-1:0] alpha;
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
    logic             last;
    logic             frame_end;
  } ftbac_sample_t;

  function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  function automatic logic [SC_W-1:0] spp_last_index(input logic [SPP_W-1:0] v);
    logic [SPP_W-1:0] e;
    e = (v == '0) ? SPP_W'(1) : ((v > MAX_SPP) ? MAX_SPP : v);
    return SC_W'(e - SPP_W'(1));
  endfunction

  function automatic logic [PC_W-1:0] pif_last_index(input logic [PIF_W-1:0] v);
    logic [PIF_W-1:0] e;
    e = (v == '0) ? PIF_W'(1) : ((v > MAX_PIF) ? MAX_PIF : v);
    return PC_W'(e - PIF_W'(1));
  endfunction

endpackage

[hdl/ftbac_front.sv]
// Front end: configuration registers, input saturation, sample and pixel counting.
// Depends on ftbac_pkg; feeds ftbac_queue.
module ftbac_front
  import ftbac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [VAL_W-1:0]      in_alpha,
  input  logic [VAL_W-1:0]      in_red,
  input  logic [VAL_W-1:0]      in_green,
  input  logic [VAL_W-1:0]      in_blue,
  output logic                  q_push,
  output ftbac_sample_t         q_entry,
  input  logic                  q_full
);

  logic [SC_W-1:0] spp_last_r;
  logic [PC_W-1:0] pif_last_r;
  logic [SC_W-1:0] sample_cnt_r, sample_cnt_nxt;
  logic [PC_W-1:0] pixel_cnt_r, pixel_cnt_nxt;
  logic            is_last;
  logic            is_frame_end;

  assign in_full = q_full;
  assign q_push = in_push && !q_full;

  assign is_last = sample_cnt_r >= spp_last_r;
  assign is_frame_end = is_last && (pixel_cnt_r >= pif_last_r);

  assign q_entry.alpha = sat_one(in_alpha);
  assign q_entry.red = sat_one(in_red);
  assign q_entry.green = sat_one(in_green);
  assign q_entry.blue = sat_one(in_blue);
  assign q_entry.last = is_last;
  assign q_entry.frame_end = is_frame_end;

  always_comb begin
    sample_cnt_nxt = is_last ? '0 : sample_cnt_r + SC_W'(1);
    pixel_cnt_nxt = pixel_cnt_r;
    if (is_last) begin
      pixel_cnt_nxt = is_frame_end ? '0 : pixel_cnt_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_last_r <= spp_last_index(SPP_RESET);
      pif_last_r <= pif_last_index(PIF_RESET);
      sample_cnt_r <= '0;
      pixel_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES_PER_PIXEL: spp_last_r <= spp_last_index(cfg_data[SPP_W-1:0]);
          REG_PIXELS_IN_FRAME:   pif_last_r <= pif_last_index(cfg_data[PIF_W-1:0]);
          default: begin
          end
        endcase
      end
      if (q_push) begin
        sample_cnt_r <= sample_cnt_nxt;
        pixel_cnt_r <= pixel_cnt_nxt;
      end
    end
  end

endmodule

[hdl/ftbac_queue.sv]
// Short sample queue that decouples the front end from the compositing back end.
// Depends on ftbac_pkg for the entry type and depth.
module ftbac_queue
  import ftbac_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ftbac_sample_t din,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output ftbac_sample_t dout
);

  ftbac_sample_t     entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full = count_r == QCNT_W'(QDEPTH);
  assign valid = count_r != '0;
  assign dout = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hdl/ftbac_back.sv]
// Back end: transmittance recurrence, weighted color accumulation and result register.
// Depends on ftbac_pkg and on the assertion macros in the defines header.
`include "front_to_back_alpha_compositor_defines.svh"

module ftbac_back
  import ftbac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ftbac_sample_t    q_entry,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [VAL_W-1:0] out_red,
  output logic [VAL_W-1:0] out_green,
  output logic [VAL_W-1:0] out_blue,
  output logic             out_frame_end
);

  logic                 advance;
  logic                 emit_hold;
  logic                 acc_ok;
  logic [VAL_W-1:0]     trans_r, trans_nxt;
  logic [2*VAL_W-1:0]   prod_t, prod_r, prod_g, prod_b;

  logic                 s1_valid_r;
  logic [VAL_W-1:0]     s1_red_r, s1_green_r, s1_blue_r, s1_alpha_r;
  logic                 s1_last_r, s1_fe_r;

  logic [2*VAL_W-1:0]   wprod_r, wprod_g, wprod_b;
  logic                 s2_valid_r;
  logic [VAL_W-1:0]     s2_red_r, s2_green_r, s2_blue_r;
  logic                 s2_last_r, s2_fe_r;

  logic [VAL_W-1:0]     acc_red_r, acc_green_r, acc_blue_r;
  logic [VAL_W:0]       sum_red, sum_green, sum_blue;
  logic [VAL_W-1:0]     acc_red_nxt, acc_green_nxt, acc_blue_nxt;

  logic                 out_valid_r;

  assign emit_hold = s2_valid_r && s2_last_r && out_valid_r;
  assign advance = !(emit_hold && !out_pop);
  assign q_pop = advance && q_valid;

  assign prod_t = q_entry.alpha > ONE ? '0
                : (2*VAL_W)'(trans_r) * (2*VAL_W)'(ONE - q_entry.alpha);
  assign prod_r = (2*VAL_W)'(q_entry.red) * (2*VAL_W)'(trans_r);
  assign prod_g = (2*VAL_W)'(q_entry.green) * (2*VAL_W)'(trans_r);
  assign prod_b = (2*VAL_W)'(q_entry.blue) * (2*VAL_W)'(trans_r);
  assign trans_nxt = q_entry.last ? ONE : prod_t[FRACTION_BITS +: VAL_W];

  assign wprod_r = (2*VAL_W)'(s1_red_r) * (2*VAL_W)'(s1_alpha_r);
  assign wprod_g = (2*VAL_W)'(s1_green_r) * (2*VAL_W)'(s1_alpha_r);
  assign wprod_b = (2*VAL_W)'(s1_blue_r) * (2*VAL_W)'(s1_alpha_r);

  assign sum_red = {1'b0, acc_red_r} + {1'b0, s2_red_r};
  assign sum_green = {1'b0, acc_green_r} + {1'b0, s2_green_r};
  assign sum_blue = {1'b0, acc_blue_r} + {1'b0, s2_blue_r};
  assign acc_red_nxt = (sum_red > {1'b0, ONE}) ? ONE : sum_red[VAL_W-1:0];
  assign acc_green_nxt = (sum_green > {1'b0, ONE}) ? ONE : sum_green[VAL_W-1:0];
  assign acc_blue_nxt = (sum_blue > {1'b0, ONE}) ? ONE : sum_blue[VAL_W-1:0];
  assign acc_ok = (acc_red_r <= ONE) && (acc_green_r <= ONE) && (acc_blue_r <= ONE);

  assign out_empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_red_r <= prod_r[FRACTION_BITS +: VAL_W];
      s1_green_r <= prod_g[FRACTION_BITS +: VAL_W];
      s1_blue_r <= prod_b[FRACTION_BITS +: VAL_W];
      s1_alpha_r <= q_entry.alpha;
      s1_last_r <= q_entry.last;
      s1_fe_r <= q_entry.frame_end;
      s2_red_r <= wprod_r[FRACTION_BITS +: VAL_W];
      s2_green_r <= wprod_g[FRACTION_BITS +: VAL_W];
      s2_blue_r <= wprod_b[FRACTION_BITS +: VAL_W];
      s2_last_r <= s1_last_r;
      s2_fe_r <= s1_fe_r;
    end
    if (advance && s2_valid_r && s2_last_r) begin
      out_red <= acc_red_nxt;
      out_green <= acc_green_nxt;
      out_blue <= acc_blue_nxt;
      out_frame_end <= s2_fe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r <= ONE;
      acc_red_r <= '0;
      acc_green_r <= '0;
      acc_blue_r <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid_r <= q_valid;
        s2_valid_r <= s1_valid_r;
        if (q_valid) begin
          trans_r <= trans_nxt;
        end
        if (s2_valid_r) begin
          acc_red_r <= s2_last_r ? '0 : acc_red_nxt;
          acc_green_r <= s2_last_r ? '0 : acc_green_nxt;
          acc_blue_r <= s2_last_r ? '0 : acc_blue_nxt;
        end
      end
      if (advance && s2_valid_r && s2_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `FTBAC_ASSERT_NOW(a_trans_range, 1'b1, trans_r <= ONE, "Transmittance above one.")
  `FTBAC_ASSERT_NOW(a_acc_range, 1'b1, acc_ok, "Accumulator above one.")
  `FTBAC_ASSERT_NEXT(a_trans_restart, q_pop && q_entry.last, trans_r == ONE, "Pixel restart missed.")
  `FTBAC_ASSERT_NEXT(a_emit_stall, emit_hold && !out_pop, emit_hold, "Result lost during a stall.")

endmodule

[hdl/front_to_back_alpha_compositor.sv]
// Front-to-back alpha compositor: accepts one sample per cycle unless in_full
// stalls it; a pixel result passes through the queue, two multiply stages and
// then the result register after its last sample is accepted, one result per
// samples_per_pixel samples. The transmittance multiply closes each cycle.
// Reset is synchronous and active low: configuration returns to 64 samples per
// pixel and 65536 pixels per frame, pixel and frame state clear at once.
module front_to_back_alpha_compositor
  import ftbac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [VAL_W-1:0]      in_alpha,
  input  logic [VAL_W-1:0]      in_red,
  input  logic [VAL_W-1:0]      in_green,
  input  logic [VAL_W-1:0]      in_blue,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [VAL_W-1:0]      out_red,
  output logic [VAL_W-1:0]      out_green,
  output logic [VAL_W-1:0]      out_blue,
  output logic                  out_frame_end
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  ftbac_sample_t q_din;
  ftbac_sample_t q_dout;

  ftbac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_alpha  (in_alpha),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .q_push    (q_push),
    .q_entry   (q_din),
    .q_full    (q_full)
  );

  ftbac_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  ftbac_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_entry       (q_dout),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

endmodule

[test/tb_top.sv]
// Self-checking testbench for front_to_back_alpha_compositor.
// Depends on ftbac_pkg; drives samples, predicts each composited pixel and
// compares every popped result, with random idling on both sides.
module tb_top
  import ftbac_pkg::*;
();

  localparam int CLK_HALF = 6;
  localparam int unsigned UNIT = 1 << FRACTION_BITS;
  localparam int unsigned HALF = UNIT / 2;
  localparam int unsigned VAL_MAX = (1 << VAL_W) - 1;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
    logic             frame_end;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_push;
  logic                  in_full;
  logic [VAL_W-1:0]      in_alpha;
  logic [VAL_W-1:0]      in_red;
  logic [VAL_W-1:0]      in_green;
  logic [VAL_W-1:0]      in_blue;
  logic                  out_empty;
  logic                  out_pop;
  logic [VAL_W-1:0]      out_red;
  logic [VAL_W-1:0]      out_green;
  logic [VAL_W-1:0]      out_blue;
  logic                  out_frame_end;

  // Predicted configuration and ray state of the compositor.
  bit [SPP_W-1:0] cfg_spp = SPP_RESET;
  bit [PIF_W-1:0] cfg_pif = PIF_RESET;
  bit [VAL_W-1:0] ray_trans = VAL_W'(UNIT);
  bit [VAL_W-1:0] sum_r = '0;
  bit [VAL_W-1:0] sum_g = '0;
  bit [VAL_W-1:0] sum_b = '0;
  bit [SC_W-1:0]  ray_pos = '0;
  bit [PC_W-1:0]  frame_pos = '0;

  pixel_t      pending_pixels[$];
  int unsigned errors = 0;
  int unsigned pixels_checked = 0;
  bit          offering = 1'b0;
  bit          cfg_active = 1'b0;
  bit          src_idles = 1'b1;
  bit          sink_idles = 1'b1;
  int unsigned sink_hold_len = 0;

  front_to_back_alpha_compositor u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_alpha      (in_alpha),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic bit [63:0] clip_unit(input bit [63:0] v);
    return (v > UNIT) ? 64'(UNIT) : v;
  endfunction

  function automatic bit [VAL_W-1:0] accumulate(input bit [VAL_W-1:0] acc,
                                               input bit [63:0] color,
                                               input bit [63:0] trans,
                                               input bit [63:0] alpha);
    bit [63:0] s;
    s = 64'(acc) + ((((color * trans) >> FRACTION_BITS) * alpha) >> FRACTION_BITS);
    return VAL_W'(clip_unit(s));
  endfunction

  // Folds one accepted sample into the ray and queues the pixel when it ends.
  task automatic blend_sample(input bit [VAL_W-1:0] a_raw, input bit [VAL_W-1:0] r_raw,
                              input bit [VAL_W-1:0] g_raw, input bit [VAL_W-1:0] b_raw);
    bit [63:0]   a;
    bit [63:0]   t;
    int unsigned spp_eff;
    int unsigned pif_eff;
    pixel_t      px;
    a = clip_unit(64'(a_raw));
    t = 64'(ray_trans);
    sum_r = accumulate(sum_r, clip_unit(64'(r_raw)), t, a);
    sum_g = accumulate(sum_g, clip_unit(64'(g_raw)), t, a);
    sum_b = accumulate(sum_b, clip_unit(64'(b_raw)), t, a);
    ray_trans = VAL_W'((t * (UNIT - a)) >> FRACTION_BITS);
    spp_eff = (cfg_spp == 0) ? 1 : ((cfg_spp > MAX_SPP) ? int'(MAX_SPP) : int'(cfg_spp));
    pif_eff = (cfg_pif == 0) ? 1 : ((cfg_pif > MAX_PIF) ? int'(MAX_PIF) : int'(cfg_pif));
    if (ray_pos < spp_eff - 1) begin
      ray_pos++;
      return;
    end
    px.red = sum_r;
    px.green = sum_g;
    px.blue = sum_b;
    px.frame_end = (frame_pos >= pif_eff - 1);
    pending_pixels.push_back(px);
    ray_trans = VAL_W'(UNIT);
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    ray_pos = '0;
    frame_pos = px.frame_end ? '0 : frame_pos + 1'b1;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("pixel %0d: %s got %0d, expected %0d", pixels_checked, what, got, want);
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      return $urandom_range(1, 3);
    end else if (r < 19) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_level(input bit opacity);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) begin
      return 0;
    end else if (r < 4) begin
      return UNIT;
    end else if (r < 6) begin
      return $urandom_range(UNIT + 1, VAL_MAX);
    end else if (r < 10) begin
      return $urandom_range(0, VAL_MAX);
    end else if (r < 16) begin
      return $urandom_range(0, UNIT);
    end
    return opacity ? $urandom_range(0, 2047) : $urandom_range(UNIT - 255, UNIT);
  endfunction

  function automatic bit [CFG_DATA_W-1:0] pick_spp_value();
    bit [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      7: v = CFG_DATA_W'($urandom_range(5, 24));
      8: v = CFG_DATA_W'($urandom_range(int'(MAX_SPP) + 1, (1 << SPP_W) - 1));
      9: v = CFG_DATA_W'($urandom_range(0, (1 << SPP_W) - 1));
      default: v = CFG_DATA_W'($urandom_range(1, 4));
    endcase
    // Bits above the register width must be dropped by the block.
    if ($urandom_range(0, 3) == 0) begin
      v[CFG_DATA_W-1:SPP_W] = (CFG_DATA_W - SPP_W)'($urandom);
    end
    return v;
  endfunction

  function automatic bit [CFG_DATA_W-1:0] pick_pif_value();
    case ($urandom_range(0, 9))
      0: return '0;
      7: return CFG_DATA_W'($urandom_range(6, 200));
      8: return CFG_DATA_W'($urandom_range(int'(MAX_PIF) + 1, (1 << PIF_W) - 1));
      9: return CFG_DATA_W'($urandom_range(0, (1 << PIF_W) - 1));
      default: return CFG_DATA_W'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic close_cfg();
    if (cfg_active) begin
      cfg_we <= 1'b0;
      cfg_active = 1'b0;
    end
  endtask

  task automatic drop_push();
    if (offering) begin
      in_push <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_active = 1'b1;
    @(posedge clk);
    case (idx)
      REG_SAMPLES_PER_PIXEL: cfg_spp = data[SPP_W-1:0];
      REG_PIXELS_IN_FRAME:   cfg_pif = data[PIF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic offer_sample(input int unsigned a, input int unsigned r,
                              input int unsigned g, input int unsigned b);
    close_cfg();
    in_push <= 1'b1;
    offering = 1'b1;
    in_alpha <= VAL_W'(a);
    in_red <= VAL_W'(r);
    in_green <= VAL_W'(g);
    in_blue <= VAL_W'(b);
    do @(posedge clk); while (in_full);
    blend_sample(VAL_W'(a), VAL_W'(r), VAL_W'(g), VAL_W'(b));
  endtask

  task automatic pause(input int unsigned n);
    drop_push();
    repeat (n) @(posedge clk);
  endtask

  // Stops sending, waits for every pending pixel, then lets queued samples drain.
  task automatic settle();
    drop_push();
    close_cfg();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_special_cases();
    // A partial pixel under the reset configuration is cut short by a smaller count.
    offer_sample(HALF, UNIT, HALF, 0);
    offer_sample(UNIT / 4, 0, UNIT, HALF);
    offer_sample(VAL_MAX, VAL_MAX, 0, UNIT);
    settle();
    write_reg(REG_SAMPLES_PER_PIXEL, CFG_DATA_W'(0));
    offer_sample(0, VAL_MAX, VAL_MAX, VAL_MAX);
    offer_sample(0, UNIT, UNIT, UNIT);
    offer_sample(UNIT, UNIT, UNIT, UNIT);
    offer_sample(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
    offer_sample(UNIT + 1, UNIT + 1, UNIT + 1, UNIT + 1);
    offer_sample(UNIT - 1, UNIT - 1, 1, 0);
    offer_sample(1, 1, UNIT - 1, VAL_MAX);
    settle();
    write_reg(REG_PIXELS_IN_FRAME, CFG_DATA_W'(0));
    offer_sample(HALF, UNIT, 0, HALF);
    offer_sample(UNIT, 0, UNIT, HALF);
    settle();
    write_reg(REG_SAMPLES_PER_PIXEL, CFG_DATA_W'(2));
    write_reg(REG_PIXELS_IN_FRAME, CFG_DATA_W'(3));
    repeat (4) offer_sample(HALF, UNIT, HALF, UNIT / 4);
    settle();
    write_reg(REG_PIXELS_IN_FRAME, CFG_DATA_W'(1));
    repeat (2) offer_sample(UNIT / 4, HALF, UNIT, 0);
    settle();
    write_reg(REG_UNUSED_2, '1);
    write_reg(REG_UNUSED_3, '1);
    write_reg(REG_SAMPLES_PER_PIXEL, {{(CFG_DATA_W - SPP_W){1'b1}}, SPP_W'(3)});
    offer_sample(UNIT, HALF, UNIT, 0);
    offer_sample(HALF, UNIT, UNIT, UNIT);
    offer_sample(HALF, UNIT, 0, UNIT);
    settle();
    write_reg(REG_SAMPLES_PER_PIXEL, CFG_DATA_W'(MAX_SPP));
    write_reg(REG_PIXELS_IN_FRAME, CFG_DATA_W'(MAX_PIF));
    repeat (2) offer_sample(UNIT / 8, UNIT, HALF, UNIT);
    settle();
    write_reg(REG_SAMPLES_PER_PIXEL, '1);
    write_reg(REG_PIXELS_IN_FRAME, '1);
    repeat (2) offer_sample(UNIT / 8, HALF, UNIT, UNIT);
    settle();
    write_reg(REG_SAMPLES_PER_PIXEL, CFG_DATA_W'(1));
    offer_sample(HALF, UNIT, UNIT, HALF);
    settle();
  endtask

  task automatic test_backpressure();
    src_idles = 1'b0;
    sink_idles = 1'b0;
    write_reg(REG_SAMPLES_PER_PIXEL, CFG_DATA_W'(1));
    write_reg(REG_PIXELS_IN_FRAME, CFG_DATA_W'(7));
    sink_hold_len = 150;
    repeat (40) offer_sample(pick_level(1'b1), pick_level(1'b0), pick_level(1'b0),
                             pick_level(1'b0));
    settle();
  endtask

  task automatic test_random_stream();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      src_idles = ($urandom_range(0, 3) != 0);
      sink_idles = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_SAMPLES_PER_PIXEL, pick_spp_value());
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_PIXELS_IN_FRAME, pick_pif_value());
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_2 : REG_UNUSED_3,
                  CFG_DATA_W'($urandom));
      end
      n = $urandom_range(10, 90);
      repeat (n) begin
        offer_sample(pick_level(1'b1), pick_level(1'b0), pick_level(1'b0),
                     pick_level(1'b0));
        if (src_idles && $urandom_range(0, 2) == 0) begin
          pause(idle_len());
        end
      end
      sent += n;
    end
  endtask

  // The result side pops at random; a requested hold-off is counted here.
  initial begin : result_sink
    int unsigned gap_left;
    int unsigned hold_left;
    gap_left = 0;
    hold_left = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_len != 0) begin
        hold_left = sink_hold_len;
        sink_hold_len = 0;
      end
      if (hold_left != 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else if (gap_left != 0) begin
        out_pop <= 1'b0;
        gap_left--;
      end else begin
        out_pop <= 1'b1;
        if (sink_idles && $urandom_range(0, 3) == 0) begin
          gap_left = idle_len();
        end
      end
    end
  end

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("transaction with no pixel pending, red", int'(out_red), 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_red !== want.red) begin
          report_mismatch("red", int'(out_red), int'(want.red));
        end
        if (out_green !== want.green) begin
          report_mismatch("green", int'(out_green), int'(want.green));
        end
        if (out_blue !== want.blue) begin
          report_mismatch("blue", int'(out_blue), int'(want.blue));
        end
        if (out_frame_end !== want.frame_end) begin
          report_mismatch("frame_end", int'(out_frame_end), int'(want.frame_end));
        end
      end
      pixels_checked++;
    end
  end

  initial begin : run_limit
    #(2 * CLK_HALF * 400000);
    $display("FAILURE");
    $finish;
  end

  initial begin : main_sequence
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_push <= 1'b0;
    in_alpha <= '0;
    in_red <= '0;
    in_green <= '0;
    in_blue <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_backpressure();
    test_random_stream();
    settle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
